>>> hw/rtl/jpd_pkg.sv
// ============================================================================
// jpd_pkg: shared types and constants for the joint path densifier
// Holds the angle, spacing and arithmetic widths and the fixed-size payload
// structs of both channels.
// ============================================================================
package jpd_pkg;

	localparam int NUM_AXES  = 6;    // payload structs carry six joints
	localparam int ANGLE_W   = 20;
	localparam int SPACING_W = 19;
	localparam int DELTA_W   = 21;
	localparam int SQ_W      = 42;
	localparam int SUM_W     = 46;   // room for up to 64 axes of squares
	localparam int SPACING_RESET = 3277;

	localparam logic [1:0] ADDR_SPACING = 2'd0;

	typedef struct packed {
		logic              path_start;
		logic signed [19:0] joint_5;
		logic signed [19:0] joint_4;
		logic signed [19:0] joint_3;
		logic signed [19:0] joint_2;
		logic signed [19:0] joint_1;
		logic signed [19:0] joint_0;
	} in_word_t;

	typedef struct packed {
		logic              last_of_run;
		logic signed [19:0] point_joint_5;
		logic signed [19:0] point_joint_4;
		logic signed [19:0] point_joint_3;
		logic signed [19:0] point_joint_2;
		logic signed [19:0] point_joint_1;
		logic signed [19:0] point_joint_0;
	} out_word_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;        // capture input word, form deltas
		logic acc_step;    // add next axis square to sum
		logic cmp_step;    // test next k for reach^2 >= sum
		logic div_start;   // start one offset division for current axis
		logic div_step;    // one restoring step
		logic div_store;   // store rounded offset of current axis
		logic out_load;    // load output register
		logic commit;      // previous <= current
	} jpd_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic pass;        // waypoint passes through
		logic acc_done;    // all axes summed
		logic n_found;     // search hit or saturated
		logic div_done;    // restoring division finished
		logic axis_last;   // current axis is the last
		logic k_last;      // current point is the last one
	} jpd_stat_t;

endpackage

>>> hw/rtl/joint_path_densifier.sv
// ============================================================================
// joint_path_densifier: joint-space linear path densification
// Pass-through word: squares are summed, then the word goes out as its point.
// The next word is accepted only once the last point of a word is taken.
// Split into n points: sum and count search, then the offsets of each point
// come axis by axis from one shared restoring divider.
// Reset clears previous waypoint, have-previous flag, sequencer; spacing=3277.
// ============================================================================
module joint_path_densifier #(
	parameter int MAX_SUBDIVISIONS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  jpd_pkg::in_word_t   in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output jpd_pkg::out_word_t  out_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	logic [jpd_pkg::SPACING_W-1:0] spacing_q;
	logic signed [jpd_pkg::ANGLE_W-1:0] cur_in [jpd_pkg::NUM_AXES];
	logic signed [jpd_pkg::ANGLE_W-1:0] pt [jpd_pkg::NUM_AXES];
	logic last;
	jpd_pkg::jpd_cmd_t  cmd;
	jpd_pkg::jpd_stat_t stat;

	// config register: single word at address 0
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) spacing_q <= jpd_pkg::SPACING_W'(jpd_pkg::SPACING_RESET);
		else if (psel && penable && pwrite && paddr == jpd_pkg::ADDR_SPACING)
			spacing_q <= pwdata[jpd_pkg::SPACING_W-1:0];
	end
	assign prdata = (paddr == jpd_pkg::ADDR_SPACING) ?
		32'(spacing_q) : 32'd0;

	// unpack joints into the datapath's axis array
	assign cur_in = '{in_word.joint_0, in_word.joint_1, in_word.joint_2,
		in_word.joint_3, in_word.joint_4, in_word.joint_5};

	jpd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd)
	);

	jpd_datapath #(.NUM_AXES(jpd_pkg::NUM_AXES), .MAX_SUBDIVISIONS(MAX_SUBDIVISIONS)) u_dp (
		.clk(clk), .arst_n(arst_n), .spacing(spacing_q),
		.cur_in(cur_in), .start_in(in_word.path_start),
		.cmd(cmd), .stat(stat), .pt_out(pt), .last_out(last)
	);

	always_comb begin
		out_word = '0;
		out_word.last_of_run = last;
		out_word.point_joint_0 = pt[0];
		out_word.point_joint_1 = pt[1];
		out_word.point_joint_2 = pt[2];
		out_word.point_joint_3 = pt[3];
		out_word.point_joint_4 = pt[4];
		out_word.point_joint_5 = pt[5];
	end
endmodule

>>> hw/rtl/jpd_datapath.sv
// ============================================================================
// jpd_datapath: densifier arithmetic
// Sum of squared deltas, serial search for the subdivision count, and a
// shared restoring divider producing each interpolated offset.
// ============================================================================
module jpd_datapath #(
	parameter int NUM_AXES = 6,
	parameter int MAX_SUBDIVISIONS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [jpd_pkg::SPACING_W-1:0]         spacing,
	input  logic signed [jpd_pkg::ANGLE_W-1:0]    cur_in [NUM_AXES],
	input  logic                                  start_in,
	input  jpd_pkg::jpd_cmd_t                     cmd,
	output jpd_pkg::jpd_stat_t                    stat,
	output logic signed [jpd_pkg::ANGLE_W-1:0]    pt_out [NUM_AXES],
	output logic                                  last_out
);
	localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int N_W  = $clog2(MAX_SUBDIVISIONS + 1);
	localparam int KD_W = jpd_pkg::DELTA_W + N_W;       // |k*delta|
	localparam int NUM_W = KD_W + 2;                    // 2*mag + n
	localparam int DEN_W = N_W + 1;                     // 2*n
	localparam int Q_W  = NUM_W;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int RCH_W = jpd_pkg::SPACING_W + N_W;

	logic signed [jpd_pkg::ANGLE_W-1:0] prev_q [NUM_AXES];
	logic signed [jpd_pkg::ANGLE_W-1:0] cur_q  [NUM_AXES];
	logic signed [jpd_pkg::DELTA_W-1:0] delta_q [NUM_AXES];
	logic signed [jpd_pkg::ANGLE_W-1:0] pt_q   [NUM_AXES];
	logic have_prev_q, start_q, last_q;
	logic [jpd_pkg::SUM_W-1:0] sum_q;
	logic [AX_W-1:0] ax_q;
	logic [N_W-1:0]  n_q, k_q;
	logic [RCH_W-1:0] reach_q;
	logic [Q_W-1:0]   rem_q, quo_q;
	logic [NUM_W-1:0] num_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;

	// current-axis delta and square
	logic signed [jpd_pkg::DELTA_W-1:0] d_sel;
	logic [jpd_pkg::DELTA_W-1:0] d_mag;
	logic [jpd_pkg::SQ_W-1:0] sq;
	logic [2*RCH_W-1:0] reach_sq;
	logic [jpd_pkg::SUM_W-1:0] lim_sq;
	logic [KD_W-1:0] kd;
	logic [Q_W-1:0]  rem_sh;
	logic [DEN_W-1:0] den;
	logic signed [jpd_pkg::DELTA_W:0] off;

	assign d_sel = delta_q[ax_q];
	assign d_mag = d_sel[jpd_pkg::DELTA_W-1] ? jpd_pkg::DELTA_W'(-d_sel) : d_sel;
	assign sq = jpd_pkg::SQ_W'(d_mag) * jpd_pkg::SQ_W'(d_mag);
	assign reach_sq = (2*RCH_W)'(reach_q) * (2*RCH_W)'(reach_q);
	assign lim_sq = jpd_pkg::SUM_W'(spacing) * jpd_pkg::SUM_W'(spacing);
	assign kd = KD_W'(d_mag) * KD_W'(k_q);
	assign den = {n_q, 1'b0};
	assign rem_sh = {rem_q[Q_W-2:0], num_q[NUM_W-1 - 0]};
	assign off = neg_q ? -(jpd_pkg::DELTA_W+1)'(quo_q) : (jpd_pkg::DELTA_W+1)'(quo_q);

	always_comb begin
		stat.pass      = start_q || !have_prev_q ||
			(jpd_pkg::SUM_W+1)'(sum_q) <= (jpd_pkg::SUM_W+1)'(lim_sq);
		stat.acc_done  = (ax_q == AX_W'(NUM_AXES - 1));
		stat.axis_last = (ax_q == AX_W'(NUM_AXES - 1));
		stat.n_found   = ((2*RCH_W+jpd_pkg::SUM_W)'(reach_sq) >=
			(2*RCH_W+jpd_pkg::SUM_W)'(sum_q)) || (n_q == N_W'(MAX_SUBDIVISIONS));
		stat.div_done  = (cnt_q == '0);
		stat.k_last    = (k_q == n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			for (int a = 0; a < NUM_AXES; a++) prev_q[a] <= '0;
		end else if (cmd.commit) begin
			have_prev_q <= 1'b1;
			prev_q <= cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q   <= cur_in;
			start_q <= start_in;
			for (int a = 0; a < NUM_AXES; a++)
				delta_q[a] <= jpd_pkg::DELTA_W'(cur_in[a]) - jpd_pkg::DELTA_W'(prev_q[a]);
			sum_q   <= '0;
			ax_q    <= '0;
			n_q     <= N_W'(1);
			k_q     <= N_W'(1);
			reach_q <= RCH_W'(spacing);
		end
		if (cmd.acc_step) begin
			sum_q <= sum_q + jpd_pkg::SUM_W'(sq);
			ax_q  <= stat.axis_last ? '0 : ax_q + AX_W'(1);
		end
		if (cmd.cmp_step) begin
			n_q     <= n_q + N_W'(1);
			reach_q <= reach_q + RCH_W'(spacing);
		end
		if (cmd.div_start) begin
			num_q <= {kd, 1'b0} + NUM_W'(n_q);
			neg_q <= d_sel[jpd_pkg::DELTA_W-1];
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= CNT_W'(NUM_W);
		end
		if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
			if (rem_sh >= Q_W'(den)) begin
				rem_q <= rem_sh - Q_W'(den);
				quo_q <= {quo_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[Q_W-2:0], 1'b0};
			end
		end
		if (cmd.div_store) begin
			pt_q[ax_q] <= jpd_pkg::ANGLE_W'(jpd_pkg::DELTA_W'(prev_q[ax_q]) +
				jpd_pkg::DELTA_W'(off));
			ax_q <= stat.axis_last ? '0 : ax_q + AX_W'(1);
		end
		if (cmd.out_load) begin
			last_q <= stat.k_last || stat.pass;
			if (stat.k_last || stat.pass) pt_out <= cur_q;
			else pt_out <= pt_q;
			k_q <= k_q + N_W'(1);
		end
	end

	assign last_out = last_q;
endmodule

>>> hw/rtl/jpd_ctrl.sv
// ============================================================================
// jpd_ctrl: densifier sequencer
// Steps the datapath through sum, count search, per-axis division (skipped
// for a pass-through word) and output hand-off for each accepted word.
// ============================================================================
module jpd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  jpd_pkg::jpd_stat_t stat,
	output jpd_pkg::jpd_cmd_t  cmd
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SUM   = 7'b0000010,
		S_SRCH  = 7'b0000100,
		S_DSTRT = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_WAIT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   ov_q, ov_d;

	wire out_free = !ov_q || !out_stall;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		ov_d = ov_q && out_stall;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				cmd.acc_step = 1'b1;
				if (stat.acc_done) state_d = S_SRCH;
			end
			S_SRCH: begin
				if (stat.pass) state_d = S_EMIT;
				else if (stat.n_found) state_d = S_DSTRT;
				else cmd.cmp_step = 1'b1;
			end
			S_DSTRT: begin
				cmd.div_start = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_store = 1'b1;
					state_d = stat.axis_last ? S_EMIT : S_DSTRT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
					if (stat.pass || stat.k_last) begin
						cmd.commit = 1'b1;
						state_d = S_WAIT;
					end else begin
						state_d = S_DSTRT;
					end
				end
			end
			S_WAIT: begin
				if (!ov_d) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;
endmodule

>>> bench/tb_joint_path_densifier.sv
// ============================================================================
// tb_joint_path_densifier: self-checking bench for the joint path densifier
// Drives waypoints with random gaps, stalls the point stream at random, and
// compares every point with a behavioral prediction of the segment split.
// Covers pass-through, path starts, split segments, saturation at the
// largest subdivision count and several spacing settings.
// ============================================================================
module tb_joint_path_densifier;

	localparam int AXES = jpd_pkg::NUM_AXES;
	localparam int MAX_DIV = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	jpd_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	jpd_pkg::out_word_t out_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	joint_path_densifier #(.MAX_SUBDIVISIONS(MAX_DIV)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// predictor state: mirror of the block's previous waypoint and spacing
	logic signed [19:0] prev_pt [AXES];
	bit have_prev;
	logic [18:0] spacing;
	jpd_pkg::out_word_t pending_points[$];
	int errors;
	int stall_left = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
	endtask

	function automatic longint round_div(input longint q, input longint n);
		longint mag;
		longint r;
		mag = (q < 0) ? -q : q;
		r = (2 * mag + n) / (2 * n);
		return (q < 0) ? -r : r;
	endfunction

	// split one waypoint into expected points
	task automatic predict_points(input jpd_pkg::in_word_t w);
		logic signed [19:0] cur [AXES];
		longint delta [AXES];
		longint sumsq;
		longint reach;
		longint sp;
		int n;
		jpd_pkg::out_word_t p;
		logic [AXES*20-1:0] flat;
		sumsq = 0;
		sp = spacing;
		flat = w[AXES*20-1:0];
		for (int a = 0; a < AXES; a++) begin
			cur[a] = flat[a*20 +: 20];
			delta[a] = longint'(cur[a]) - longint'(prev_pt[a]);
			sumsq += delta[a] * delta[a];
		end
		if (w.path_start || !have_prev || sumsq <= sp * sp) begin
			p = w;
			p.last_of_run = 1'b1;
			pending_points.insert(pending_points.size(), p);
		end else begin
			n = MAX_DIV;
			for (int k = 1; k <= MAX_DIV; k++) begin
				reach = k * sp;
				if (reach * reach >= sumsq) begin
					n = k;
					break;
				end
			end
			for (int k = 1; k <= n; k++) begin
				for (int a = 0; a < AXES; a++)
					flat[a*20 +: 20] = 20'(longint'(prev_pt[a]) + round_div(k * delta[a], n));
				p = {(k == n), flat};
				pending_points.insert(pending_points.size(), p);
			end
		end
		for (int a = 0; a < AXES; a++)
			prev_pt[a] = cur[a];
		have_prev = 1'b1;
	endtask

	// sends one waypoint after a random gap; valid stays up across a zero gap
	task automatic send_waypoint(input jpd_pkg::in_word_t w);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_points(w);
	endtask

	// output side: compare each accepted point, then hold stall for a drawn count
	always @(posedge clk) begin
		jpd_pkg::out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_points.size() == 0) begin
					report_mismatch("unexpected point", 1, 0);
				end else begin
					want = pending_points.pop_front();
					if (out_word.point_joint_0 !== want.point_joint_0)
						report_mismatch("joint_0", out_word.point_joint_0, want.point_joint_0);
					if (out_word.point_joint_1 !== want.point_joint_1)
						report_mismatch("joint_1", out_word.point_joint_1, want.point_joint_1);
					if (out_word.point_joint_2 !== want.point_joint_2)
						report_mismatch("joint_2", out_word.point_joint_2, want.point_joint_2);
					if (out_word.point_joint_3 !== want.point_joint_3)
						report_mismatch("joint_3", out_word.point_joint_3, want.point_joint_3);
					if (out_word.point_joint_4 !== want.point_joint_4)
						report_mismatch("joint_4", out_word.point_joint_4, want.point_joint_4);
					if (out_word.point_joint_5 !== want.point_joint_5)
						report_mismatch("joint_5", out_word.point_joint_5, want.point_joint_5);
					if (out_word.last_of_run !== want.last_of_run)
						report_mismatch("last_of_run", out_word.last_of_run, want.last_of_run);
				end
				stall_left = $urandom_range(0, 10);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// waits until every predicted point has come, then lets the block return to idle
	task automatic drain_points();
		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_spacing(input logic [18:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= jpd_pkg::ADDR_SPACING;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		spacing = value;
		@(posedge clk);
		psel <= 1'b1;
		paddr <= jpd_pkg::ADDR_SPACING;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[18:0] !== value)
			report_mismatch("spacing readback", prdata, value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic jpd_pkg::in_word_t make_word(input logic start, input int span,
		input bit near);
		jpd_pkg::in_word_t w;
		logic [AXES*20-1:0] flat;
		longint v;
		for (int a = 0; a < AXES; a++) begin
			if (near) begin
				v = longint'(prev_pt[a]) + $signed($urandom_range(0, 2 * span)) - span;
				if (v > 524287) v = 524287;
				if (v < -524288) v = -524288;
				flat[a*20 +: 20] = 20'(v);
			end else begin
				flat[a*20 +: 20] = 20'($urandom);
			end
		end
		w = {start, flat};
		return w;
	endfunction

	task automatic test_directed();
		jpd_pkg::in_word_t w;
		// waypoint with no previous one: passes through
		send_waypoint({1'b0, {AXES{20'sd1000}}});
		// short step: passes through
		send_waypoint({1'b0, {AXES{20'sd1200}}});
		// split segment, positive and negative deltas, rounding ties
		send_waypoint({1'b0, 20'sd9000, -20'sd7000, 20'sd5000, 20'sd1200, 20'sd1201, 20'sd0});
		// extremes of every axis, long segment saturates
		send_waypoint({1'b0, {AXES{20'h7FFFF}}});
		send_waypoint({1'b0, {AXES{20'h80000}}});
		// path start on a far point: passes through
		send_waypoint({1'b1, {AXES{20'h7FFFF}}});
		// same point again: zero distance
		send_waypoint({1'b0, {AXES{20'h7FFFF}}});
		send_waypoint({1'b1, {AXES{20'h00000}}});
		for (int i = 0; i < 6; i++) begin
			w = '0;
			w[i*20 +: 20] = (i % 2) ? 20'h80000 : 20'h7FFFF;
			send_waypoint(w);
		end
		drain_points();
	endtask

	task automatic test_random(input int count);
		jpd_pkg::in_word_t w;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				w = make_word(1'b1, 0, 1'b0);
			else if (pick < 3)
				w = make_word(1'b0, 0, 1'b0);
			else
				w = make_word(1'b0, (pick < 6) ? 3000 : 20000, 1'b1);
			send_waypoint(w);
		end
		drain_points();
	endtask

	initial begin
		errors = 0;
		have_prev = 1'b0;
		spacing = 19'(jpd_pkg::SPACING_RESET);
		for (int a = 0; a < AXES; a++) prev_pt[a] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		write_spacing(19'd1);
		test_random(20);
		write_spacing(19'h7FFFF);
		test_random(30);
		write_spacing(19'd20000);
		test_random(60);
		write_spacing(19'(jpd_pkg::SPACING_RESET));
		test_random(60);

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// worst case: 64 points per word plus stalls, far below this timeout
	initial begin
		#240000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
